// ===== rtl/sfp_pkg.sv =====
// shared types, codes and constants for the sync frame parser
package sfp_pkg;

  // default store sizes
  localparam int PAYLOAD_MAX_DEF = 256;
  localparam int RAW_MAX_DEF     = 1024;

  // frame markers
  localparam logic [7:0] SYNC_CHAR1 = 8'hB5;
  localparam logic [7:0] SYNC_CHAR2 = 8'h62;
  localparam logic [7:0] RAW_CLASS  = 8'h02;
  localparam logic [7:0] RAW_ID     = 8'h10;

  // rebuilt header bytes ahead of the raw payload
  localparam int RAW_HDR_LEN = 6;
  // header plus checksum bytes counted in the raw size
  localparam int RAW_OVERHEAD = 8;
  // checksum bytes stored after the raw payload
  localparam int CK_LEN = 2;

  // operation codes
  localparam logic [1:0] OP_RX      = 2'd0;
  localparam logic [1:0] OP_RD_PAY  = 2'd1;
  localparam logic [1:0] OP_RD_RAW  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_GOOD  = 2'd0;
  localparam logic [1:0] KIND_RAW   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // parser states
  typedef enum logic [3:0] {
    ST_SYNC1,
    ST_SYNC2,
    ST_CLASS,
    ST_ID,
    ST_LEN1,
    ST_LEN2,
    ST_DATA,
    ST_CKA,
    ST_CKB,
    ST_RAW
  } parse_state_t;

  // where the read data of the output word comes from
  typedef enum logic [1:0] {
    SRC_REG,
    SRC_PAY,
    SRC_RAW
  } rd_src_t;

  // frame result from the parser
  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [9:0]  payload_length;
    logic [10:0] raw_size;
  } frame_res_t;

endpackage

// ===== rtl/sfp_ram.sv =====
// generic single write port ram with registered read
module sfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sfp_parser.sv =====
// byte parser: sync hunt, header capture, fletcher sum and store write control
module sfp_parser #(
  parameter int PAYLOAD_MAX = sfp_pkg::PAYLOAD_MAX_DEF,
  parameter int RAW_MAX     = sfp_pkg::RAW_MAX_DEF,
  localparam int CNT_W = $clog2((PAYLOAD_MAX > RAW_MAX ? PAYLOAD_MAX : RAW_MAX) + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_valid,
  input  logic [7:0]         rx_byte,
  output sfp_pkg::frame_res_t res,
  output logic               pay_we,
  output logic               raw_we,
  output logic [CNT_W-1:0]   wr_cnt,
  output logic [15:0]        raw_hdr_len
);

  sfp_pkg::parse_state_t state_r, state_nxt;
  logic [7:0]       class_r, class_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       sum_a_r, sum_a_nxt;
  logic [7:0]       sum_b_r, sum_b_nxt;
  logic [7:0]       rsa_r, rsa_nxt;
  logic [15:0]      hdr_len_r, hdr_len_nxt;

  logic [7:0]  sum_a_add;
  logic [7:0]  sum_b_add;
  logic [16:0] cnt_inc;
  logic [15:0] len_full;

  // running fletcher update for the current byte
  assign sum_a_add = sum_a_r + rx_byte;
  assign sum_b_add = sum_b_r + sum_a_add;
  assign cnt_inc   = 17'(cnt_r) + 17'd1;
  assign len_full  = {rx_byte, len_r[7:0]};

  assign wr_cnt      = cnt_r;
  assign raw_hdr_len = hdr_len_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfp_pkg::ST_SYNC1;
    end else begin
      state_r <= state_nxt;
    end
  end

  // frame registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_r   <= '0;
      id_r      <= '0;
      len_r     <= '0;
      cnt_r     <= '0;
      sum_a_r   <= '0;
      sum_b_r   <= '0;
      rsa_r     <= '0;
      hdr_len_r <= '0;
    end else begin
      class_r   <= class_nxt;
      id_r      <= id_nxt;
      len_r     <= len_nxt;
      cnt_r     <= cnt_nxt;
      sum_a_r   <= sum_a_nxt;
      sum_b_r   <= sum_b_nxt;
      rsa_r     <= rsa_nxt;
      hdr_len_r <= hdr_len_nxt;
    end
  end

  // next state, store writes and frame results
  always_comb begin
    state_nxt   = state_r;
    class_nxt   = class_r;
    id_nxt      = id_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    sum_a_nxt   = sum_a_r;
    sum_b_nxt   = sum_b_r;
    rsa_nxt     = rsa_r;
    hdr_len_nxt = hdr_len_r;
    res         = '0;
    pay_we      = 1'b0;
    raw_we      = 1'b0;
    if (byte_valid) begin
      case (state_r)
        sfp_pkg::ST_SYNC1: begin
          if (rx_byte == sfp_pkg::SYNC_CHAR1) begin
            state_nxt = sfp_pkg::ST_SYNC2;
          end
        end
        sfp_pkg::ST_SYNC2: begin
          if (rx_byte == sfp_pkg::SYNC_CHAR2) begin
            state_nxt = sfp_pkg::ST_CLASS;
            sum_a_nxt = '0;
            sum_b_nxt = '0;
          end else begin
            state_nxt = sfp_pkg::ST_SYNC1;
          end
        end
        sfp_pkg::ST_CLASS: begin
          class_nxt = rx_byte;
          sum_a_nxt = sum_a_add;
          sum_b_nxt = sum_b_add;
          state_nxt = sfp_pkg::ST_ID;
        end
        sfp_pkg::ST_ID: begin
          id_nxt    = rx_byte;
          sum_a_nxt = sum_a_add;
          sum_b_nxt = sum_b_add;
          state_nxt = sfp_pkg::ST_LEN1;
        end
        sfp_pkg::ST_LEN1: begin
          len_nxt   = {8'h00, rx_byte};
          sum_a_nxt = sum_a_add;
          sum_b_nxt = sum_b_add;
          state_nxt = sfp_pkg::ST_LEN2;
        end
        sfp_pkg::ST_LEN2: begin
          len_nxt   = len_full;
          sum_a_nxt = sum_a_add;
          sum_b_nxt = sum_b_add;
          cnt_nxt   = '0;
          // raw path, oversize drop, empty frame or payload
          if (class_r == sfp_pkg::RAW_CLASS && id_r == sfp_pkg::RAW_ID) begin
            if (17'(len_full) + 17'(sfp_pkg::RAW_OVERHEAD) > 17'(RAW_MAX)) begin
              state_nxt = sfp_pkg::ST_SYNC1;
            end else begin
              state_nxt = sfp_pkg::ST_RAW;
            end
          end else if (17'(len_full) > 17'(PAYLOAD_MAX)) begin
            state_nxt = sfp_pkg::ST_SYNC1;
          end else if (len_full == 16'd0) begin
            state_nxt = sfp_pkg::ST_CKA;
          end else begin
            state_nxt = sfp_pkg::ST_DATA;
          end
        end
        sfp_pkg::ST_DATA: begin
          sum_a_nxt = sum_a_add;
          sum_b_nxt = sum_b_add;
          pay_we    = 1'b1;
          cnt_nxt   = CNT_W'(cnt_inc);
          if (cnt_inc >= 17'(len_r)) begin
            state_nxt = sfp_pkg::ST_CKA;
          end
        end
        sfp_pkg::ST_CKA: begin
          rsa_nxt   = rx_byte;
          state_nxt = sfp_pkg::ST_CKB;
        end
        sfp_pkg::ST_CKB: begin
          state_nxt = sfp_pkg::ST_SYNC1;
          // both checksum bytes must match
          if (sum_a_r == rsa_r && sum_b_r == rx_byte) begin
            res.valid          = 1'b1;
            res.kind           = sfp_pkg::KIND_GOOD;
            res.msg_class      = class_r;
            res.msg_id         = id_r;
            res.payload_length = len_r[9:0];
          end
        end
        sfp_pkg::ST_RAW: begin
          raw_we  = 1'b1;
          cnt_nxt = CNT_W'(cnt_inc);
          // payload and checksum bytes all stored
          if (cnt_inc == 17'(len_r) + 17'(sfp_pkg::CK_LEN)) begin
            state_nxt          = sfp_pkg::ST_SYNC1;
            hdr_len_nxt        = len_r;
            res.valid          = 1'b1;
            res.kind           = sfp_pkg::KIND_RAW;
            res.msg_class      = sfp_pkg::RAW_CLASS;
            res.msg_id         = sfp_pkg::RAW_ID;
            res.payload_length = len_r[9:0];
            res.raw_size       = 11'(len_r + 16'(sfp_pkg::RAW_OVERHEAD));
          end
        end
        default: begin
          state_nxt = sfp_pkg::ST_SYNC1;
        end
      endcase
    end
  end

endmodule

// ===== rtl/sync_frame_parser_fletcher8.sv =====
// Sync frame parser with 8-bit fletcher check, payload store and raw store.
// Throughput: one word per cycle while the result side takes words; a stalled
// result word holds the input, since the output register is the only stage.
// Timing: a result word shows in the cycle after the word that causes it; read
// data comes from the store's registered read port in that same cycle.
// Reset: synchronous active low, clears parser and output valid; stores keep content.
module sync_frame_parser_fletcher8 #(
  parameter int PAYLOAD_MAX = sfp_pkg::PAYLOAD_MAX_DEF,
  parameter int RAW_MAX     = sfp_pkg::RAW_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // rx_byte[7:0], read_index[17:8], zero fill [23:18]
  input  logic [23:0] in_tdata,
  // op[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // msg_class[7:0], msg_id[15:8], payload_length[25:16], raw_size[36:26],
  // read_data[44:37], zero fill [47:45]
  output logic [47:0] out_tdata,
  // kind[1:0]
  output logic [1:0]  out_tuser
);

  localparam int PA_W  = $clog2(PAYLOAD_MAX);
  localparam int RA_W  = $clog2(RAW_MAX);
  localparam int CNT_W = $clog2((PAYLOAD_MAX > RAW_MAX ? PAYLOAD_MAX : RAW_MAX) + 1);

  logic        accept;
  logic [1:0]  in_op;
  logic [7:0]  in_byte;
  logic [9:0]  in_idx;
  logic        byte_valid;

  sfp_pkg::frame_res_t res;
  logic             pay_we, raw_we;
  logic [CNT_W-1:0] wr_cnt;
  logic [15:0]      raw_hdr_len;

  logic             pay_re, raw_re;
  logic [7:0]       pay_rdata, raw_rdata;
  logic [7:0]       hdr_byte;
  logic             pay_in_range, raw_in_range, raw_in_hdr;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [7:0]       cls_r, cls_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [9:0]       len_r, len_nxt;
  logic [10:0]      size_r, size_nxt;
  logic [7:0]       rdata_r, rdata_nxt;
  sfp_pkg::rd_src_t src_r, src_nxt;
  logic [7:0]       read_data;

  // input word fields
  assign in_op      = in_tuser;
  assign in_byte    = in_tdata[7:0];
  assign in_idx     = in_tdata[17:8];
  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign byte_valid = accept && (in_op == sfp_pkg::OP_RX);

  sfp_parser #(
    .PAYLOAD_MAX (PAYLOAD_MAX),
    .RAW_MAX     (RAW_MAX)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (byte_valid),
    .rx_byte     (in_byte),
    .res         (res),
    .pay_we      (pay_we),
    .raw_we      (raw_we),
    .wr_cnt      (wr_cnt),
    .raw_hdr_len (raw_hdr_len)
  );

  // read range checks
  assign pay_in_range = 32'(in_idx) < 32'(PAYLOAD_MAX);
  assign raw_in_range = 32'(in_idx) < 32'(RAW_MAX);
  assign raw_in_hdr   = in_idx < 10'(sfp_pkg::RAW_HDR_LEN);
  assign pay_re = accept && (in_op == sfp_pkg::OP_RD_PAY) && pay_in_range;
  assign raw_re = accept && (in_op == sfp_pkg::OP_RD_RAW) && raw_in_range && !raw_in_hdr;

  sfp_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_MAX)
  ) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (PA_W'(wr_cnt)),
    .wdata (in_byte),
    .re    (pay_re),
    .raddr (PA_W'(in_idx)),
    .rdata (pay_rdata)
  );

  sfp_ram #(
    .WIDTH (8),
    .DEPTH (RAW_MAX)
  ) u_raw_ram (
    .clk   (clk),
    .we    (raw_we),
    .waddr (RA_W'(wr_cnt + CNT_W'(sfp_pkg::RAW_HDR_LEN))),
    .wdata (in_byte),
    .re    (raw_re),
    .raddr (RA_W'(in_idx)),
    .rdata (raw_rdata)
  );

  // rebuilt raw header bytes
  always_comb begin
    case (in_idx[2:0])
      3'd0:    hdr_byte = sfp_pkg::SYNC_CHAR1;
      3'd1:    hdr_byte = sfp_pkg::SYNC_CHAR2;
      3'd2:    hdr_byte = sfp_pkg::RAW_CLASS;
      3'd3:    hdr_byte = sfp_pkg::RAW_ID;
      3'd4:    hdr_byte = raw_hdr_len[7:0];
      3'd5:    hdr_byte = raw_hdr_len[15:8];
      default: hdr_byte = 8'h00;
    endcase
  end

  // output register load
  always_comb begin
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    cls_nxt       = cls_r;
    id_nxt        = id_r;
    len_nxt       = len_r;
    size_nxt      = size_r;
    rdata_nxt     = rdata_r;
    src_nxt       = src_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      case (in_op)
        sfp_pkg::OP_RX: begin
          if (res.valid) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = res.kind;
            cls_nxt       = res.msg_class;
            id_nxt        = res.msg_id;
            len_nxt       = res.payload_length;
            size_nxt      = res.raw_size;
            rdata_nxt     = 8'h00;
            src_nxt       = sfp_pkg::SRC_REG;
          end
        end
        sfp_pkg::OP_RD_PAY: begin
          out_valid_nxt = 1'b1;
          kind_nxt      = sfp_pkg::KIND_READ;
          cls_nxt       = '0;
          id_nxt        = '0;
          len_nxt       = '0;
          size_nxt      = '0;
          rdata_nxt     = 8'h00;
          src_nxt       = pay_in_range ? sfp_pkg::SRC_PAY : sfp_pkg::SRC_REG;
        end
        sfp_pkg::OP_RD_RAW: begin
          out_valid_nxt = 1'b1;
          kind_nxt      = sfp_pkg::KIND_READ;
          cls_nxt       = '0;
          id_nxt        = '0;
          len_nxt       = '0;
          size_nxt      = '0;
          rdata_nxt     = raw_in_hdr ? hdr_byte : 8'h00;
          src_nxt       = (raw_in_range && !raw_in_hdr) ? sfp_pkg::SRC_RAW
                                                        : sfp_pkg::SRC_REG;
        end
        default: begin
          out_valid_nxt = out_valid_nxt;
        end
      endcase
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    cls_r   <= cls_nxt;
    id_r    <= id_nxt;
    len_r   <= len_nxt;
    size_r  <= size_nxt;
    rdata_r <= rdata_nxt;
    src_r   <= src_nxt;
  end

  // read data select, ram outputs hold until the next read
  always_comb begin
    case (src_r)
      sfp_pkg::SRC_PAY: read_data = pay_rdata;
      sfp_pkg::SRC_RAW: read_data = raw_rdata;
      default:          read_data = rdata_r;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {3'b000, read_data, size_r, len_r, id_r, cls_r};

endmodule
